@@ rtl/ccs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ccs_pkg;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam int MAX_RES = 4;

	// Results caused by one accepted word.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [2:0]              count;
		logic                    last;
		logic                    present;
	} bundle_t;

endpackage
`default_nettype wire

@@ rtl/ccs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccs_front
	import ccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] char_in,
	input  wire logic       flush,
	output bundle_t         bundle,
	output logic            push
);

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_STRING = 2'd1,
		MODE_LINE   = 2'd2,
		MODE_BLOCK  = 2'd3
	} scan_mode_t;

	scan_mode_t      mode_q;
	logic [2:0][7:0] look_q;
	logic [1:0]      held_q;
	logic [7:0]      leb_q;
	logic            ea_q;
	logic [7:0]      pcb_q;
	logic            cls_q;
	logic            dnn_q;

	scan_mode_t      mode_d;
	logic [2:0][7:0] look_d;
	logic [1:0]      held_d;
	logic [7:0]      leb_d;
	logic            ea_d;
	logic [7:0]      pcb_d;
	logic            cls_d;
	logic            dnn_d;

	function automatic logic [7:0] byte_at(input logic [3:0][7:0] w, input logic [2:0] idx);
		return idx[2] ? 8'h00 : w[idx[1:0]];
	endfunction

	function automatic logic [2:0] pair_len(input logic [7:0] p0, input logic [7:0] p1,
			input logic [7:0] p2, input logic [7:0] p3, input logic [2:0] avail,
			input logic [7:0] first, input logic [7:0] second);
		logic [2:0] r;
		r = 3'd0;
		if (avail >= 3'd2 && p0 == first) begin
			if (p1 == second) begin
				r = 3'd2;
			end else if (avail == 3'd4 && p1 == CH_BSL && p2 == CH_NL && p3 == second) begin
				r = 3'd4;
			end
		end
		return r;
	endfunction

	always_comb begin
		logic [3:0][7:0] w;
		logic [2:0]      n;
		logic [2:0]      head;
		logic [2:0]      avail;
		logic [2:0]      k;
		logic [2:0]      kl;
		logic [2:0]      kb;
		logic [2:0]      nout;
		logic [7:0]      p0;
		logic [7:0]      p1;
		logic [7:0]      p2;
		logic [7:0]      p3;
		logic            emit;
		logic            skip;
		logic [2:0]      rem;

		w[0] = (held_q == 2'd0) ? char_in : look_q[0];
		w[1] = (held_q == 2'd1) ? char_in : ((held_q > 2'd1) ? look_q[1] : 8'h00);
		w[2] = (held_q == 2'd2) ? char_in : ((held_q == 2'd3) ? look_q[2] : 8'h00);
		w[3] = (held_q == 2'd3) ? char_in : 8'h00;
		n = {1'b0, held_q} + 3'd1;
		head = 3'd0;
		nout = 3'd0;
		mode_d = mode_q;
		leb_d = leb_q;
		ea_d = ea_q;
		pcb_d = pcb_q;
		cls_d = cls_q;
		dnn_d = dnn_q;
		bundle = '0;
		avail = 3'd0;
		k = 3'd0;
		kl = 3'd0;
		kb = 3'd0;
		p0 = 8'h00;
		p1 = 8'h00;
		p2 = 8'h00;
		p3 = 8'h00;
		emit = 1'b0;
		skip = 1'b0;

		for (int it = 0; it < 8; it++) begin
			if (head < n && ((n - head) == 3'd4 || flush)) begin
				avail = n - head;
				p0 = byte_at(w, head);
				p1 = byte_at(w, head + 3'd1);
				p2 = byte_at(w, head + 3'd2);
				p3 = byte_at(w, head + 3'd3);
				case (mode_d)
					MODE_BLOCK: begin
						k = pair_len(p0, p1, p2, p3, avail, CH_STAR, CH_SLASH);
						if (k != 3'd0) begin
							head = head + k;
							mode_d = MODE_PLAIN;
							dnn_d = 1'b1;
						end else begin
							head = head + 3'd1;
						end
					end
					MODE_LINE: begin
						if (p0 == CH_NL && pcb_d != CH_BSL) begin
							mode_d = MODE_PLAIN;
							if (cls_d) begin
								head = head + 3'd1;
							end
						end else begin
							pcb_d = p0;
							head = head + 3'd1;
						end
					end
					default: begin
						emit = 1'b1;
						skip = 1'b0;
						if (dnn_d) begin
							dnn_d = 1'b0;
							if (p0 == CH_NL && ea_d && leb_d == CH_NL) begin
								head = head + 3'd1;
								skip = 1'b1;
							end
						end
						if (!skip) begin
							kl = pair_len(p0, p1, p2, p3, avail, CH_SLASH, CH_SLASH);
							kb = pair_len(p0, p1, p2, p3, avail, CH_SLASH, CH_STAR);
							if (p0 == CH_QUOTE && !(ea_d && leb_d == CH_BSL)) begin
								mode_d = (mode_d == MODE_PLAIN) ? MODE_STRING : MODE_PLAIN;
							end else if (mode_d == MODE_PLAIN && kl != 3'd0) begin
								cls_d = !ea_d || leb_d == CH_NL;
								pcb_d = CH_SLASH;
								mode_d = MODE_LINE;
								head = head + kl;
								emit = 1'b0;
							end else if (mode_d == MODE_PLAIN && kb != 3'd0) begin
								mode_d = MODE_BLOCK;
								head = head + kb;
								emit = 1'b0;
							end
							if (emit) begin
								if (nout < 3'd4) begin
									bundle.bytes[nout[1:0]] = p0;
									nout = nout + 3'd1;
								end
								leb_d = p0;
								ea_d = 1'b1;
								head = head + 3'd1;
							end
						end
					end
				endcase
			end
		end

		rem = n - head;
		held_d = rem[1:0];
		look_d[0] = byte_at(w, head);
		look_d[1] = byte_at(w, head + 3'd1);
		look_d[2] = byte_at(w, head + 3'd2);
		bundle.present = 1'b1;
		bundle.last = flush;
		if (flush) begin
			if (nout == 3'd0) begin
				nout = 3'd1;
				bundle.present = 1'b0;
			end
			mode_d = MODE_PLAIN;
			held_d = 2'd0;
			leb_d = 8'h00;
			ea_d = 1'b0;
			pcb_d = 8'h00;
			cls_d = 1'b0;
			dnn_d = 1'b0;
		end
		bundle.count = nout;
		push = accept && nout != 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			held_q <= 2'd0;
			leb_q <= 8'h00;
			ea_q <= 1'b0;
			pcb_q <= 8'h00;
			cls_q <= 1'b0;
			dnn_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
			leb_q <= leb_d;
			ea_q <= ea_d;
			pcb_q <= pcb_d;
			cls_q <= cls_d;
			dnn_q <= dnn_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			look_q <= look_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ccs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccs_queue
	import ccs_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_data,
	output logic         full,
	input  wire logic    pop,
	output bundle_t      pop_data,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ccs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccs_back
	import ccs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire bundle_t    head,
	input  wire logic       empty,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);

	logic [1:0] idx_q;
	logic       load;
	logic       at_end;

	assign load = !empty && (!m_tvalid || m_tready);
	assign at_end = {1'b0, idx_q} == head.count - 3'd1;
	assign pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			m_tvalid <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid <= 1'b1;
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= head.bytes[idx_q];
			m_tuser <= head.present;
			m_tlast <= head.last && at_end;
		end
	end

endmodule
`default_nettype wire

@@ rtl/c_comment_stripper_unit.sv @@
// Path: a byte enters the result queue once its deciding word is accepted, then the output
// register; that word is three bytes later, or end-of-text, which decides all held bytes.
// Throughput: one word per cycle while the result queue is not full; an end-of-text word
// yields up to four output words; the QUEUE_DEPTH-entry queue absorbs them as input continues.
// Reset: arst_n clears scan state and the queue at once; held lookahead bytes are not reset.
`timescale 1ns / 1ps
`default_nettype none
module c_comment_stripper_unit
	import ccs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // char_in
	input  wire logic       s_tlast,   // end_of_text
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // char_out
	output logic            m_tuser,   // char_present
	output logic            m_tlast    // last_out
);

	bundle_t push_data;
	bundle_t head;
	logic    push;
	logic    full;
	logic    empty;
	logic    pop;

	assign s_tready = !full;

	ccs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (s_tvalid && s_tready),
		.char_in (s_tdata),
		.flush   (s_tlast),
		.bundle  (push_data),
		.push    (push)
	);

	ccs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	ccs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

@@ rtl/ccs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ccs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tuser,
	input wire logic       m_tlast
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output word withdrawn while stalled.");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("Output word changed while stalled.");

	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("Bare end marker is not the last word.");

	a_bare_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 8'h00)
		else $error("Bare end marker carries a byte.");

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import ccs_pkg::*;

	localparam int  TEXT_BYTES = 370;
	localparam int  HOLD_AT    = 150;
	localparam int  DRAIN_AT   = 260;
	localparam int  HOLD_LEN   = 80;
	localparam int  DIR_N      = 28;

	typedef enum logic [1:0] {M_PLAIN, M_STR, M_LINE, M_BLOCK} scan_e;

	typedef struct packed {
		logic [7:0] ch;
		logic       present;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       typed;
		logic [7:0] w_ch;
		logic       w_present;
		logic       w_last;
	} dir_row_t;

	// Directed texts: single bytes at the extremes, comments cut off at end of text,
	// the opener overlap, a string at the very start, a block with a split closer
	// followed by a newline, and a split line opener whose comment is continued
	// by a backslash-newline.
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
		'{8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_STAR, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
		'{CH_QUOTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_QUOTE, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_NL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_STAR, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_STAR, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_NL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_NL, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{8'h78, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_NL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_SLASH, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_BSL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_NL, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{8'h71, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CH_NL, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	c_comment_stripper_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	scan_e      mode;
	logic [7:0] held [3];
	int         held_n;
	logic [7:0] last_byte;
	logic       any_out;
	logic [7:0] prev_cbyte;
	logic       line_start;
	logic       drop_nl;
	logic [7:0] win [4];
	out_word_t  step_out [4];
	int         step_n;

	out_word_t  stripped_q [$];
	logic [7:0] text_q [$];
	int         mismatch_count = 0;
	int         words_checked = 0;
	int         sent = 0;
	int         texts = 0;
	int         burst_left = 0;
	bit         holdoff_req = 1'b0;

	task automatic clear_state();
		mode = M_PLAIN;
		held_n = 0;
		last_byte = 8'h00;
		any_out = 1'b0;
		prev_cbyte = 8'h00;
		line_start = 1'b0;
		drop_nl = 1'b0;
	endtask

	function automatic int pair_at(int pos, int avail, logic [7:0] first, logic [7:0] second);
		if (avail < 2 || win[pos] != first)
			return 0;
		if (win[pos+1] == second)
			return 2;
		if (avail >= 4 && win[pos+1] == CH_BSL && win[pos+2] == CH_NL && win[pos+3] == second)
			return 4;
		return 0;
	endfunction

	task automatic strip_byte(input logic [7:0] c, input logic eot);
		int         n;
		int         head;
		int         k_line;
		int         k_block;
		int         k;
		int         i;
		logic [7:0] b;
		n = held_n;
		for (i = 0; i < n; i++)
			win[i] = held[i];
		win[n] = c;
		n++;
		head = 0;
		step_n = 0;
		while (head < n && (n - head == 4 || eot)) begin
			b = win[head];
			if (mode == M_BLOCK) begin
				k = pair_at(head, n - head, CH_STAR, CH_SLASH);
				if (k != 0) begin
					head += k;
					mode = M_PLAIN;
					drop_nl = 1'b1;
				end else begin
					head++;
				end
			end else if (mode == M_LINE) begin
				if (b == CH_NL && prev_cbyte != CH_BSL) begin
					mode = M_PLAIN;
					if (line_start)
						head++;
				end else begin
					prev_cbyte = b;
					head++;
				end
			end else if (drop_nl && b == CH_NL && any_out && last_byte == CH_NL) begin
				drop_nl = 1'b0;
				head++;
			end else begin
				drop_nl = 1'b0;
				k_line = (mode == M_PLAIN) ? pair_at(head, n - head, CH_SLASH, CH_SLASH) : 0;
				k_block = (mode == M_PLAIN) ? pair_at(head, n - head, CH_SLASH, CH_STAR) : 0;
				if (b == CH_QUOTE && !(any_out && last_byte == CH_BSL)) begin
					mode = (mode == M_PLAIN) ? M_STR : M_PLAIN;
					k_line = 0;
					k_block = 0;
				end
				if (k_line != 0) begin
					line_start = !any_out || last_byte == CH_NL;
					prev_cbyte = CH_SLASH;
					mode = M_LINE;
					head += k_line;
				end else if (k_block != 0) begin
					mode = M_BLOCK;
					head += k_block;
				end else begin
					step_out[step_n] = '{b, 1'b1, 1'b0};
					step_n++;
					last_byte = b;
					any_out = 1'b1;
					head++;
				end
			end
		end
		if (eot) begin
			if (step_n > 0) begin
				step_out[step_n-1].last = 1'b1;
			end else begin
				step_out[0] = '{8'h00, 1'b0, 1'b1};
				step_n = 1;
			end
			clear_state();
		end else begin
			held_n = n - head;
			for (i = 0; i < held_n; i++)
				held[i] = win[head + i];
		end
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_out
		out_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			words_checked++;
			if (stripped_q.size() == 0) begin
				flag_mismatch("unexpected word", m_tdata, 0);
			end else begin
				want = stripped_q.pop_front();
				if (m_tdata != want.ch)
					flag_mismatch("char_out", m_tdata, want.ch);
				if (m_tuser != want.present)
					flag_mismatch("char_present", m_tuser, want.present);
				if (m_tlast != want.last)
					flag_mismatch("last_out", m_tlast, want.last);
			end
		end
	end

	initial begin : receiver
		int style;
		int style_left;
		int holdoff_left;
		style = 0;
		style_left = 0;
		holdoff_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				holdoff_left = HOLD_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_tready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style = $urandom_range(0, 3);
					style_left = $urandom_range(20, 100);
				end
				style_left--;
				case (style)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin
		#2_000_000;
		$display("** c_comment_stripper_unit: FAILED **");
		$finish;
	end

	task automatic send_word(input logic [7:0] c, input logic eot, input logic typed,
			input out_word_t want);
		int i;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		strip_byte(c, eot);
		if (typed) begin
			stripped_q.push_back(want);
		end else begin
			for (i = 0; i < step_n; i++)
				stripped_q.push_back(step_out[i]);
		end
		sent++;
		if (eot)
			texts++;
	endtask

	task automatic pace();
		int gap;
		if (sent == HOLD_AT)
			holdoff_req = 1'b1;
		if (sent == DRAIN_AT) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			while (stripped_q.size() != 0)
				@(posedge clk);
		end
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
	endtask

	function automatic logic [7:0] plain_char();
		if ($urandom_range(0, 5) == 0)
			return 8'h20;
		return 8'($urandom_range(8'h61, 8'h7A));
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(0, 4))
			0: return CH_SLASH;
			1: return CH_STAR;
			2: return CH_BSL;
			3: return CH_NL;
			default: return CH_QUOTE;
		endcase
	endfunction

	task automatic maybe_split();
		if ($urandom_range(0, 3) == 0) begin
			text_q.push_back(CH_BSL);
			text_q.push_back(CH_NL);
		end
	endtask

	task automatic add_body(input int len);
		repeat (len) begin
			case ($urandom_range(0, 5))
				0: text_q.push_back(special_char());
				1: begin
					text_q.push_back(CH_BSL);
					text_q.push_back(CH_NL);
				end
				default: text_q.push_back(plain_char());
			endcase
		end
	endtask

	task automatic add_token();
		case ($urandom_range(0, 9))
			0, 1: repeat ($urandom_range(1, 4)) text_q.push_back(plain_char());
			2: text_q.push_back(CH_NL);
			3: begin
				text_q.push_back(CH_SLASH);
				maybe_split();
				text_q.push_back(CH_SLASH);
				add_body($urandom_range(0, 5));
				text_q.push_back(CH_NL);
			end
			4: begin
				text_q.push_back(CH_SLASH);
				maybe_split();
				text_q.push_back(CH_STAR);
				add_body($urandom_range(0, 6));
				text_q.push_back(CH_STAR);
				maybe_split();
				text_q.push_back(CH_SLASH);
			end
			5: begin
				text_q.push_back(CH_QUOTE);
				repeat ($urandom_range(0, 4)) begin
					case ($urandom_range(0, 3))
						0: begin
							text_q.push_back(CH_BSL);
							text_q.push_back(CH_QUOTE);
						end
						1: begin
							text_q.push_back(CH_SLASH);
							text_q.push_back(CH_SLASH);
						end
						default: text_q.push_back(plain_char());
					endcase
				end
				text_q.push_back(CH_QUOTE);
			end
			6: text_q.push_back(special_char());
			7: text_q.push_back(8'($urandom_range(0, 255)));
			8: begin
				text_q.push_back(CH_SLASH);
				text_q.push_back(CH_STAR);
				text_q.push_back(CH_SLASH);
				add_body($urandom_range(0, 3));
				text_q.push_back(CH_STAR);
				text_q.push_back(CH_SLASH);
			end
			default: begin
				text_q.push_back(CH_NL);
				text_q.push_back(CH_SLASH);
				text_q.push_back(CH_STAR);
				text_q.push_back(CH_STAR);
				text_q.push_back(CH_SLASH);
				text_q.push_back(CH_NL);
			end
		endcase
	endtask

	initial begin : stimulus
		int        r;
		int        i;
		out_word_t want;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		clear_state();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < DIR_N; r++) begin
			pace();
			want = '{DIR_ROWS[r].w_ch, DIR_ROWS[r].w_present, DIR_ROWS[r].w_last};
			send_word(DIR_ROWS[r].ch, DIR_ROWS[r].eot, DIR_ROWS[r].typed, want);
		end

		while (sent < TEXT_BYTES) begin
			text_q.delete();
			repeat ($urandom_range(1, 8)) add_token();
			for (i = 0; i < text_q.size(); i++) begin
				pace();
				send_word(text_q[i], i == text_q.size() - 1, 1'b0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (stripped_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d source bytes in %0d texts and checked %0d output words.",
			sent, texts, words_checked);
		$display("Run included a long output hold-off and a full drain pause mid-stream.");
		if (mismatch_count == 0) begin
			$display("** c_comment_stripper_unit: PASSED **");
		end else begin
			$display("** c_comment_stripper_unit: FAILED **");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/ccs_pkg.sv
rtl/ccs_front.sv
rtl/ccs_queue.sv
rtl/ccs_back.sv
rtl/c_comment_stripper_unit.sv
rtl/ccs_checker.sv
dv/tb.sv
